>>> src/rhp_pkg.sv
// Shared types, codes and lookup functions for the request header parser.
package rhp_pkg;

	typedef struct packed {
		logic       op;
		logic [7:0] in_byte;
	} req_t;

	typedef struct packed {
		logic [3:0] tag;
		logic [7:0] out_byte;
		logic [1:0] command_kind;
		logic       done_res;
		logic [3:0] error_code;
	} res_t;

	typedef enum logic [6:0] {
		PH_START   = 7'b0000001,
		PH_VERSION = 7'b0000010,
		PH_COMMAND = 7'b0000100,
		PH_NAME    = 7'b0001000,
		PH_VALUE   = 7'b0010000,
		PH_MESSAGE = 7'b0100000,
		PH_FAILED  = 7'b1000000
	} phase_t;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_END  = 1'b1;

	localparam logic [3:0] TAG_NONE      = 4'd0;
	localparam logic [3:0] TAG_VERSION   = 4'd1;
	localparam logic [3:0] TAG_NAME      = 4'd2;
	localparam logic [3:0] TAG_VALUE     = 4'd3;
	localparam logic [3:0] TAG_MESSAGE   = 4'd4;
	localparam logic [3:0] TAG_VER_END   = 4'd5;
	localparam logic [3:0] TAG_CMD_END   = 4'd6;
	localparam logic [3:0] TAG_NAME_END  = 4'd7;
	localparam logic [3:0] TAG_VALUE_END = 4'd8;
	localparam logic [3:0] TAG_HDRS_END  = 4'd9;

	localparam logic [1:0] KIND_NONE   = 2'd0;
	localparam logic [1:0] KIND_RAW    = 2'd1;
	localparam logic [1:0] KIND_STORED = 2'd2;

	localparam logic [3:0] ERR_OK          = 4'd0;
	localparam logic [3:0] ERR_VER_START   = 4'd1;
	localparam logic [3:0] ERR_VER_SHORT   = 4'd2;
	localparam logic [3:0] ERR_VER_CHAR    = 4'd3;
	localparam logic [3:0] ERR_CMD_SHORT   = 4'd4;
	localparam logic [3:0] ERR_CMD_CHAR    = 4'd5;
	localparam logic [3:0] ERR_CMD_UNKNOWN = 4'd6;
	localparam logic [3:0] ERR_HDR_SHORT   = 4'd7;
	localparam logic [3:0] ERR_HDR_CHAR    = 4'd8;
	localparam logic [3:0] ERR_MSG_CHAR    = 4'd9;

	localparam logic [4:0] LEN_MAX    = 5'd31;
	localparam logic [4:0] RAW_LEN    = 5'd8;
	localparam logic [4:0] STORED_LEN = 5'd15;

	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A)) ||
			((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	// Characters of "RawQuery".
	function automatic logic [7:0] raw_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = "R";
			3'd1: c = "a";
			3'd2: c = "w";
			3'd3: c = "Q";
			3'd4: c = "u";
			3'd5: c = "e";
			3'd6: c = "r";
			default: c = "y";
		endcase
		return c;
	endfunction

	// Characters of "StoredProcedure"; index 15 is past the end.
	function automatic logic [7:0] stored_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0:  c = "S";
			4'd1:  c = "t";
			4'd2:  c = "o";
			4'd3:  c = "r";
			4'd4:  c = "e";
			4'd5:  c = "d";
			4'd6:  c = "P";
			4'd7:  c = "r";
			4'd8:  c = "o";
			4'd9:  c = "c";
			4'd10: c = "e";
			4'd11: c = "d";
			4'd12: c = "u";
			4'd13: c = "r";
			4'd14: c = "e";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

>>> src/rhp_step.sv
// Parser state registers and the per-item phase update logic.
module rhp_step (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  rhp_pkg::req_t item,
	output rhp_pkg::res_t result
);

	rhp_pkg::phase_t phase_q, phase_d;
	logic [4:0] len_q, len_d;
	logic [1:0] match_q, match_d;
	logic [3:0] held_q, held_d;

	logic [7:0] c;
	logic [4:0] len_bump;
	logic       raw_hit, stored_hit;
	logic       restart;
	logic [3:0] err;

	assign c        = item.in_byte;
	assign len_bump = (len_q < rhp_pkg::LEN_MAX) ? len_q + 5'd1 : len_q;
	assign raw_hit  = (len_q < rhp_pkg::RAW_LEN) && (rhp_pkg::raw_char(len_q[2:0]) == c);
	assign stored_hit = (len_q < rhp_pkg::STORED_LEN) &&
		(rhp_pkg::stored_char(len_q[3:0]) == c);

	always_comb begin
		result   = '0;
		phase_d  = phase_q;
		len_d    = len_q;
		match_d  = match_q;
		held_d   = held_q;
		restart  = 1'b0;
		err      = rhp_pkg::ERR_OK;

		if (phase_q == rhp_pkg::PH_FAILED) begin
			result.error_code = held_q;
			restart = (item.op == rhp_pkg::OP_END);
		end else if (item.op == rhp_pkg::OP_END) begin
			result.done_res = 1'b1;
			case (phase_q)
				rhp_pkg::PH_START:   result.error_code = rhp_pkg::ERR_VER_START;
				rhp_pkg::PH_VERSION: result.error_code = rhp_pkg::ERR_VER_SHORT;
				rhp_pkg::PH_COMMAND: result.error_code = rhp_pkg::ERR_CMD_SHORT;
				rhp_pkg::PH_NAME:    result.error_code = rhp_pkg::ERR_HDR_SHORT;
				rhp_pkg::PH_VALUE:   result.error_code = rhp_pkg::ERR_HDR_SHORT;
				default:             result.error_code = rhp_pkg::ERR_OK;
			endcase
			restart = 1'b1;
		end else begin
			case (phase_q)
				rhp_pkg::PH_START: begin
					if (rhp_pkg::is_digit(c)) begin
						result.tag      = rhp_pkg::TAG_VERSION;
						result.out_byte = c;
						phase_d         = rhp_pkg::PH_VERSION;
					end else begin
						err = rhp_pkg::ERR_VER_START;
					end
				end
				rhp_pkg::PH_VERSION: begin
					if (rhp_pkg::is_digit(c) || c == rhp_pkg::CH_DOT) begin
						result.tag      = rhp_pkg::TAG_VERSION;
						result.out_byte = c;
					end else if (c == rhp_pkg::CH_SEMI) begin
						result.tag = rhp_pkg::TAG_VER_END;
						phase_d    = rhp_pkg::PH_COMMAND;
						len_d      = '0;
						match_d    = 2'b11;
					end else begin
						err = rhp_pkg::ERR_VER_CHAR;
					end
				end
				rhp_pkg::PH_COMMAND: begin
					if (rhp_pkg::is_alnum(c)) begin
						match_d = match_q & {stored_hit, raw_hit};
						len_d   = len_bump;
					end else if (c == rhp_pkg::CH_SEMI) begin
						if (match_q[0] && len_q == rhp_pkg::RAW_LEN) begin
							result.command_kind = rhp_pkg::KIND_RAW;
						end else if (match_q[1] && len_q == rhp_pkg::STORED_LEN) begin
							result.command_kind = rhp_pkg::KIND_STORED;
						end
						if (result.command_kind != rhp_pkg::KIND_NONE) begin
							result.tag = rhp_pkg::TAG_CMD_END;
							phase_d    = rhp_pkg::PH_NAME;
							len_d      = '0;
						end else begin
							err = rhp_pkg::ERR_CMD_UNKNOWN;
						end
					end else begin
						err = rhp_pkg::ERR_CMD_CHAR;
					end
				end
				rhp_pkg::PH_NAME: begin
					if (rhp_pkg::is_alnum(c)) begin
						result.tag      = rhp_pkg::TAG_NAME;
						result.out_byte = c;
						len_d           = len_bump;
					end else if (c == rhp_pkg::CH_COLON && len_q != '0) begin
						result.tag = rhp_pkg::TAG_NAME_END;
						phase_d    = rhp_pkg::PH_VALUE;
					end else if (c == rhp_pkg::CH_SEMI && len_q == '0) begin
						result.tag = rhp_pkg::TAG_HDRS_END;
						phase_d    = rhp_pkg::PH_MESSAGE;
					end else begin
						err = rhp_pkg::ERR_HDR_CHAR;
					end
				end
				rhp_pkg::PH_VALUE: begin
					if (rhp_pkg::is_alnum(c)) begin
						result.tag      = rhp_pkg::TAG_VALUE;
						result.out_byte = c;
					end else if (c == rhp_pkg::CH_SEMI) begin
						result.tag = rhp_pkg::TAG_VALUE_END;
						phase_d    = rhp_pkg::PH_NAME;
						len_d      = '0;
					end else begin
						err = rhp_pkg::ERR_HDR_CHAR;
					end
				end
				default: begin
					if (rhp_pkg::is_alnum(c) || c == rhp_pkg::CH_SPACE ||
						c == rhp_pkg::CH_STAR || c == rhp_pkg::CH_EQ) begin
						result.tag      = rhp_pkg::TAG_MESSAGE;
						result.out_byte = c;
					end else begin
						err = rhp_pkg::ERR_MSG_CHAR;
					end
				end
			endcase
			// A format error drops the field output and parks the parser.
			if (err != rhp_pkg::ERR_OK) begin
				result            = '0;
				result.done_res   = 1'b1;
				result.error_code = err;
				held_d            = err;
				phase_d           = rhp_pkg::PH_FAILED;
			end
		end

		if (restart) begin
			phase_d = rhp_pkg::PH_START;
			len_d   = '0;
			match_d = 2'b11;
			held_d  = rhp_pkg::ERR_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rhp_pkg::PH_START;
			len_q   <= '0;
			match_q <= 2'b11;
			held_q  <= rhp_pkg::ERR_OK;
		end else if (advance) begin
			phase_q <= phase_d;
			len_q   <= len_d;
			match_q <= match_d;
			held_q  <= held_d;
		end
	end

endmodule

>>> src/request_header_parser.sv
// Top level of the request header parser: input register, parse step and result register.
// An accepted item waits in the input register until the result register can take it,
// then its result is registered there for the consumer to take.
// Throughput: one item per cycle without res_stall; each item gives exactly one result.
// The parse phase update is a single short step, so the limit is the handshake only.
// Reset (arst_n low) empties both registers and returns the parser to the start of a request.
module request_header_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  rhp_pkg::req_t req,
	output logic          res_valid,
	input  logic          res_stall,
	output rhp_pkg::res_t res
);

	// Input register: holds one accepted item until the parse step can run on it.
	logic          valid_s1;
	rhp_pkg::req_t item_s1;

	// Result register: holds the finished result until the consumer takes it.
	logic          valid_s2;
	rhp_pkg::res_t res_s2;

	logic          advance;
	logic          load_s1;
	rhp_pkg::res_t step_res;

	// The item in the input register moves on when the result register is
	// empty or is being emptied in this cycle. The parser state commits at
	// the same edge, so each item updates the state exactly once.
	assign advance = valid_s1 && (!valid_s2 || !res_stall);

	// A new item is taken whenever the input register is empty or drains now,
	// so one more item can still enter while a result waits in the output register.
	assign req_stall = valid_s1 && !advance;
	assign load_s1   = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1 || advance) begin
			valid_s1 <= load_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1 <= req;
		end
	end

	rhp_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.result  (step_res)
	);

	// The result register fills from the step and empties when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!res_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= step_res;
		end
	end

	assign res_valid = valid_s2;
	assign res       = res_s2;

endmodule

>>> tb/request_header_parser_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the request header parser: directed table, random requests, scoreboard.
module request_header_parser_tb;

	localparam int HALF_PERIOD   = 4;
	localparam int RESET_CYCLES  = 7;
	localparam int DIRECTED_ROWS = 25;
	localparam int RANDOM_ITEMS  = 1000;
	// The long receiver hold is the longest stretch in which no item may move.
	localparam int HOLD_CYCLES   = 300;
	localparam int QUIET_LIMIT   = 3000;
	// Results trail their items through the input and result registers, so a short drain is plenty.
	localparam int DRAIN_CYCLES  = 16;
	localparam int PRINT_LIMIT   = 20;

	// The two command words, first letter in the top byte.
	localparam logic [63:0]  RAW_WORD    = "RawQuery";
	localparam logic [119:0] STORED_WORD = "StoredProcedure";

	localparam rhp_pkg::req_t END_ITEM = {rhp_pkg::OP_END, 8'h00};
	localparam rhp_pkg::res_t NO_RES   = '0;

	// One row of the directed table. When typed is set, want is the result to check
	// against; otherwise the predictor supplies the expectation.
	typedef struct packed {
		rhp_pkg::req_t item;
		logic          typed;
		rhp_pkg::res_t want;
	} stim_row_t;

	// How the receiver stalls while no long hold is in progress.
	typedef enum logic [1:0] {
		RX_FREE,
		RX_RANDOM,
		RX_PATTERN
	} rx_style_t;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_stall;
	rhp_pkg::req_t req       = '0;
	logic          res_valid;
	logic          res_stall = 1'b0;
	rhp_pkg::res_t res;

	// Travels alongside req so the monitor knows which items carry a typed expectation.
	logic          typed_row  = 1'b0;
	rhp_pkg::res_t typed_want = '0;

	// Predictor state: the parser's phase, the length of the current command or
	// header name, which command words still match, and the code of a failed request.
	rhp_pkg::phase_t cur_phase;
	logic [4:0]      field_len;
	logic [1:0]      cand_match;
	logic [3:0]      held_code;

	// Expected results, oldest first.
	rhp_pkg::res_t pending_results [$];
	rhp_pkg::res_t want_res;
	rhp_pkg::res_t next_res;

	int items_sent      = 0;
	int results_seen    = 0;
	int mismatches      = 0;
	int requests_sent   = 0;
	int clean_requests  = 0;
	int failed_requests = 0;
	int raw_commands    = 0;
	int stored_commands = 0;
	int quiet_cycles    = 0;

	// Sender and receiver pacing.
	logic      tx_bursty     = 1'b1;
	int        burst_left    = 0;
	rx_style_t rx_style      = RX_RANDOM;
	int        rx_tick       = 0;
	int        hold_requests = 0;
	int        holds_served  = 0;
	int        hold_left     = 0;

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	request_header_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	// Character classes are plain ASCII; bytes from 128 up are neither digits nor letters.
	function automatic logic digit_char(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic word_char(input logic [7:0] c);
		return digit_char(c) || ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	endfunction

	// Back to the start of a request, with both command words still candidates.
	function automatic void clear_parse();
		cur_phase  = rhp_pkg::PH_START;
		field_len  = '0;
		cand_match = 2'b11;
		held_code  = rhp_pkg::ERR_OK;
	endfunction

	// Advances the predictor by one item and returns the result it must cause.
	function automatic rhp_pkg::res_t parse_step(input rhp_pkg::req_t item);
		rhp_pkg::res_t r;
		logic [7:0]    c;
		int            pos;
		r   = NO_RES;
		c   = item.in_byte;
		pos = int'(field_len);
		if (cur_phase == rhp_pkg::PH_FAILED) begin
			// A failed request swallows everything quietly, repeating its code, until
			// the end marker clears it.
			r.error_code = held_code;
			if (item.op == rhp_pkg::OP_END)
				clear_parse();
		end else if (item.op == rhp_pkg::OP_END) begin
			// The end marker finishes the request: cleanly only in the message phase.
			r.done_res = 1'b1;
			case (cur_phase)
				rhp_pkg::PH_START:   r.error_code = rhp_pkg::ERR_VER_START;
				rhp_pkg::PH_VERSION: r.error_code = rhp_pkg::ERR_VER_SHORT;
				rhp_pkg::PH_COMMAND: r.error_code = rhp_pkg::ERR_CMD_SHORT;
				rhp_pkg::PH_NAME, rhp_pkg::PH_VALUE:
					r.error_code = rhp_pkg::ERR_HDR_SHORT;
				default:             r.error_code = rhp_pkg::ERR_OK;
			endcase
			clear_parse();
		end else begin
			case (cur_phase)
				rhp_pkg::PH_START: begin
					if (digit_char(c)) begin
						r.tag      = rhp_pkg::TAG_VERSION;
						r.out_byte = c;
						cur_phase  = rhp_pkg::PH_VERSION;
					end else
						r.error_code = rhp_pkg::ERR_VER_START;
				end
				rhp_pkg::PH_VERSION: begin
					if (digit_char(c) || c == rhp_pkg::CH_DOT) begin
						r.tag      = rhp_pkg::TAG_VERSION;
						r.out_byte = c;
					end else if (c == rhp_pkg::CH_SEMI) begin
						r.tag      = rhp_pkg::TAG_VER_END;
						cur_phase  = rhp_pkg::PH_COMMAND;
						field_len  = '0;
						cand_match = 2'b11;
					end else
						r.error_code = rhp_pkg::ERR_VER_CHAR;
				end
				rhp_pkg::PH_COMMAND: begin
					// Command letters are silent; a candidate drops out at its first
					// differing letter or once the command runs past its length.
					if (word_char(c)) begin
						if (field_len >= rhp_pkg::RAW_LEN ||
							RAW_WORD[8 * (7 - pos) +: 8] != c)
							cand_match[0] = 1'b0;
						if (field_len >= rhp_pkg::STORED_LEN ||
							STORED_WORD[8 * (14 - pos) +: 8] != c)
							cand_match[1] = 1'b0;
						if (field_len != rhp_pkg::LEN_MAX)
							field_len = field_len + 5'd1;
					end else if (c == rhp_pkg::CH_SEMI) begin
						if (cand_match[0] && field_len == rhp_pkg::RAW_LEN)
							r.command_kind = rhp_pkg::KIND_RAW;
						else if (cand_match[1] && field_len == rhp_pkg::STORED_LEN)
							r.command_kind = rhp_pkg::KIND_STORED;
						if (r.command_kind != rhp_pkg::KIND_NONE) begin
							r.tag     = rhp_pkg::TAG_CMD_END;
							cur_phase = rhp_pkg::PH_NAME;
							field_len = '0;
						end else
							r.error_code = rhp_pkg::ERR_CMD_UNKNOWN;
					end else
						r.error_code = rhp_pkg::ERR_CMD_CHAR;
				end
				rhp_pkg::PH_NAME: begin
					// An empty name followed by ';' closes the header list.
					if (word_char(c)) begin
						r.tag      = rhp_pkg::TAG_NAME;
						r.out_byte = c;
						if (field_len != rhp_pkg::LEN_MAX)
							field_len = field_len + 5'd1;
					end else if (c == rhp_pkg::CH_COLON && field_len != 0) begin
						r.tag     = rhp_pkg::TAG_NAME_END;
						cur_phase = rhp_pkg::PH_VALUE;
					end else if (c == rhp_pkg::CH_SEMI && field_len == 0) begin
						r.tag     = rhp_pkg::TAG_HDRS_END;
						cur_phase = rhp_pkg::PH_MESSAGE;
					end else
						r.error_code = rhp_pkg::ERR_HDR_CHAR;
				end
				rhp_pkg::PH_VALUE: begin
					if (word_char(c)) begin
						r.tag      = rhp_pkg::TAG_VALUE;
						r.out_byte = c;
					end else if (c == rhp_pkg::CH_SEMI) begin
						r.tag     = rhp_pkg::TAG_VALUE_END;
						cur_phase = rhp_pkg::PH_NAME;
						field_len = '0;
					end else
						r.error_code = rhp_pkg::ERR_HDR_CHAR;
				end
				default: begin
					if (word_char(c) || c == rhp_pkg::CH_SPACE || c == rhp_pkg::CH_STAR ||
						c == rhp_pkg::CH_EQ) begin
						r.tag      = rhp_pkg::TAG_MESSAGE;
						r.out_byte = c;
					end else
						r.error_code = rhp_pkg::ERR_MSG_CHAR;
				end
			endcase
			// The first format error finishes the request and parks the parser.
			if (r.error_code != rhp_pkg::ERR_OK) begin
				r.done_res = 1'b1;
				held_code  = r.error_code;
				cur_phase  = rhp_pkg::PH_FAILED;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("mismatch on result %0d: %s is %0d, expected %0d",
				results_seen, what, got, want);
	endtask

	function automatic rhp_pkg::req_t byte_item(input logic [7:0] c);
		return {rhp_pkg::OP_BYTE, c};
	endfunction

	function automatic stim_row_t check_row(input rhp_pkg::req_t item, input logic [3:0] tag,
			input logic [7:0] ob, input logic [1:0] kind, input logic done,
			input logic [3:0] err);
		return {item, 1'b1, tag, ob, kind, done, err};
	endfunction

	function automatic stim_row_t model_row(input rhp_pkg::req_t item);
		return {item, 1'b0, NO_RES};
	endfunction

	// The directed table: the start-of-request failures, the quiet failed phase, then
	// one complete RawQuery request that walks every tag and ends cleanly.
	function automatic stim_row_t directed_row(input int idx);
		stim_row_t row;
		case (idx)
			// An end marker or a non-digit first byte fails the version at once.
			0: row = check_row(END_ITEM, rhp_pkg::TAG_NONE, 8'h00, rhp_pkg::KIND_NONE, 1'b1,
				rhp_pkg::ERR_VER_START);
			1: row = check_row(byte_item(8'hFF), rhp_pkg::TAG_NONE, 8'h00,
				rhp_pkg::KIND_NONE, 1'b1, rhp_pkg::ERR_VER_START);
			// The failed request now repeats its code without done until its end marker.
			2: row = check_row(byte_item(8'h00), rhp_pkg::TAG_NONE, 8'h00,
				rhp_pkg::KIND_NONE, 1'b0, rhp_pkg::ERR_VER_START);
			3: row = check_row(END_ITEM, rhp_pkg::TAG_NONE, 8'h00, rhp_pkg::KIND_NONE, 1'b0,
				rhp_pkg::ERR_VER_START);
			4: row = check_row(byte_item("9"), rhp_pkg::TAG_VERSION, "9", rhp_pkg::KIND_NONE,
				1'b0, rhp_pkg::ERR_OK);
			5: row = check_row(byte_item(rhp_pkg::CH_DOT), rhp_pkg::TAG_VERSION,
				rhp_pkg::CH_DOT, rhp_pkg::KIND_NONE, 1'b0, rhp_pkg::ERR_OK);
			6: row = check_row(byte_item(rhp_pkg::CH_SEMI), rhp_pkg::TAG_VER_END, 8'h00,
				rhp_pkg::KIND_NONE, 1'b0, rhp_pkg::ERR_OK);
			// The command letters themselves give no tag.
			7, 8, 9, 10, 11, 12, 13, 14:
				row = model_row(byte_item(RAW_WORD[8 * (14 - idx) +: 8]));
			15: row = check_row(byte_item(rhp_pkg::CH_SEMI), rhp_pkg::TAG_CMD_END, 8'h00,
				rhp_pkg::KIND_RAW, 1'b0, rhp_pkg::ERR_OK);
			16: row = check_row(byte_item("z"), rhp_pkg::TAG_NAME, "z", rhp_pkg::KIND_NONE,
				1'b0, rhp_pkg::ERR_OK);
			17: row = check_row(byte_item(rhp_pkg::CH_COLON), rhp_pkg::TAG_NAME_END, 8'h00,
				rhp_pkg::KIND_NONE, 1'b0, rhp_pkg::ERR_OK);
			18: row = check_row(byte_item("A"), rhp_pkg::TAG_VALUE, "A", rhp_pkg::KIND_NONE,
				1'b0, rhp_pkg::ERR_OK);
			19: row = check_row(byte_item(rhp_pkg::CH_SEMI), rhp_pkg::TAG_VALUE_END, 8'h00,
				rhp_pkg::KIND_NONE, 1'b0, rhp_pkg::ERR_OK);
			20: row = check_row(byte_item(rhp_pkg::CH_SEMI), rhp_pkg::TAG_HDRS_END, 8'h00,
				rhp_pkg::KIND_NONE, 1'b0, rhp_pkg::ERR_OK);
			21: row = model_row(byte_item(rhp_pkg::CH_STAR));
			22: row = model_row(byte_item(rhp_pkg::CH_SPACE));
			23: row = model_row(byte_item(rhp_pkg::CH_EQ));
			24: row = check_row(END_ITEM, rhp_pkg::TAG_NONE, 8'h00, rhp_pkg::KIND_NONE, 1'b1,
				rhp_pkg::ERR_OK);
			default: row = model_row(END_ITEM);
		endcase
		return row;
	endfunction

	function automatic logic [7:0] rand_digit();
		logic [7:0] c;
		c = "0" + 8'($urandom_range(0, 9));
		return c;
	endfunction

	function automatic logic [7:0] rand_word_char();
		logic [7:0] c;
		case ($urandom_range(0, 2))
			0: c = rand_digit();
			1: c = "a" + 8'($urandom_range(0, 25));
			default: c = "A" + 8'($urandom_range(0, 25));
		endcase
		return c;
	endfunction

	function automatic logic [7:0] rand_message_char();
		logic [7:0] c;
		case ($urandom_range(0, 5))
			0: c = rhp_pkg::CH_SPACE;
			1: c = rhp_pkg::CH_STAR;
			2: c = rhp_pkg::CH_EQ;
			default: c = rand_word_char();
		endcase
		return c;
	endfunction

	// Offers one item and returns at the edge where it is accepted. In bursty mode the
	// sender drops valid for a random gap whenever its current burst runs out.
	task automatic send_item(input rhp_pkg::req_t item, input logic typed,
			input rhp_pkg::res_t want);
		int gap;
		if (tx_bursty) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap        = $urandom_range(1, 6);
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end else
				burst_left--;
		end
		req        <= item;
		typed_row  <= typed;
		typed_want <= want;
		req_valid  <= 1'b1;
		do
			@(posedge clk);
		while (!(req_valid && !req_stall));
		items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] c);
		send_item(byte_item(c), 1'b0, NO_RES);
	endtask

	task automatic send_end();
		send_item(END_ITEM, 1'b0, NO_RES);
	endtask

	// Builds one request with random content: mostly well formed so that the parse
	// reaches the headers and the message, sometimes with one byte replaced at random
	// or cut short by an early end marker.
	task automatic send_request();
		logic [7:0] body [$];
		int         n;
		int         cut;
		int         flaw;
		int         pick;

		// Version: a leading digit, then digits and dots.
		body.push_back(rand_digit());
		repeat ($urandom_range(0, 3))
			body.push_back(($urandom_range(0, 3) == 0) ? rhp_pkg::CH_DOT : rand_digit());
		body.push_back(rhp_pkg::CH_SEMI);

		// Command: mostly one of the two words, else a random word (at times long enough to
		// saturate the length) or a prefix of the longer word, maybe with its last
		// letter swapped.
		pick = $urandom_range(0, 9);
		if (pick < 4) begin
			for (int i = 7; i >= 0; i--)
				body.push_back(RAW_WORD[8 * i +: 8]);
		end else if (pick < 8) begin
			for (int i = 14; i >= 0; i--)
				body.push_back(STORED_WORD[8 * i +: 8]);
		end else if (pick == 8) begin
			repeat ($urandom_range(0, 36))
				body.push_back(rand_word_char());
		end else begin
			n = $urandom_range(1, 15);
			for (int i = 0; i < n; i++)
				body.push_back(STORED_WORD[8 * (14 - i) +: 8]);
			if ($urandom_range(0, 1) == 1)
				body[body.size() - 1] = rand_word_char();
		end
		body.push_back(rhp_pkg::CH_SEMI);

		// Headers, with the odd empty or very long name, then the closing ';'.
		repeat ($urandom_range(0, 3)) begin
			n = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 34) : $urandom_range(1, 6);
			repeat (n)
				body.push_back(rand_word_char());
			body.push_back(rhp_pkg::CH_COLON);
			repeat ($urandom_range(0, 5))
				body.push_back(rand_word_char());
			body.push_back(rhp_pkg::CH_SEMI);
		end
		body.push_back(rhp_pkg::CH_SEMI);

		repeat ($urandom_range(0, 8))
			body.push_back(rand_message_char());

		flaw = $urandom_range(0, 5);
		cut  = $urandom_range(0, body.size() - 1);
		if (flaw == 0)
			body[cut] = 8'($urandom_range(0, 255));
		n = (flaw == 1) ? cut : body.size();
		for (int i = 0; i < n; i++)
			send_byte(body[i]);
		send_end();
	endtask

	// Pure noise: random bytes over the whole range with stray end markers.
	task automatic send_noise();
		repeat ($urandom_range(1, 12)) begin
			if ($urandom_range(0, 7) == 0)
				send_end();
			else
				send_byte(8'($urandom_range(0, 255)));
		end
		send_end();
	endtask

	// Monitor, scoreboard and receiver. Results are checked before the item accepted at
	// the same edge is predicted, so the order within a time step never matters.
	always @(posedge clk) begin
		if (res_valid && !res_stall) begin
			results_seen++;
			if (pending_results.size() == 0)
				report_mismatch("result with nothing expected", int'(res), 0);
			else begin
				want_res = pending_results.pop_front();
				if (res.tag != want_res.tag)
					report_mismatch("tag", int'(res.tag), int'(want_res.tag));
				if (res.out_byte != want_res.out_byte)
					report_mismatch("out_byte", int'(res.out_byte), int'(want_res.out_byte));
				if (res.command_kind != want_res.command_kind)
					report_mismatch("command_kind", int'(res.command_kind),
						int'(want_res.command_kind));
				if (res.done_res != want_res.done_res)
					report_mismatch("done_res", int'(res.done_res), int'(want_res.done_res));
				if (res.error_code != want_res.error_code)
					report_mismatch("error_code", int'(res.error_code),
						int'(want_res.error_code));
			end
		end

		// The predictor always steps, even on rows whose expectation is typed in.
		if (req_valid && !req_stall) begin
			next_res = parse_step(req);
			if (typed_row)
				next_res = typed_want;
			pending_results.push_back(next_res);
			if (next_res.done_res && next_res.error_code == rhp_pkg::ERR_OK)
				clean_requests++;
			else if (next_res.done_res)
				failed_requests++;
			if (next_res.command_kind == rhp_pkg::KIND_RAW)
				raw_commands++;
			else if (next_res.command_kind == rhp_pkg::KIND_STORED)
				stored_commands++;
		end

		// A long hold, once asked for, is counted out here; otherwise the receiver
		// follows its current stall style.
		if (hold_left != 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else if (holds_served != hold_requests) begin
			holds_served++;
			hold_left = HOLD_CYCLES - 1;
			res_stall <= 1'b1;
		end else begin
			case (rx_style)
				RX_FREE:   res_stall <= 1'b0;
				RX_RANDOM: res_stall <= ($urandom_range(0, 2) == 0);
				default:   res_stall <= ((rx_tick % 7) >= 4);
			endcase
		end
		rx_tick++;
	end

	// Watchdog: the run is stuck if no item moves on either side for too long.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (res_valid && !res_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		stim_row_t row;

		clear_parse();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			row = directed_row(i);
			send_item(row.item, row.typed, row.want);
		end

		while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
			// Every few requests the pacing on both sides changes, including stretches
			// with no gaps and no stalls at all.
			if (requests_sent % 4 == 0) begin
				tx_bursty = ($urandom_range(0, 2) != 0);
				rx_style  = rx_style_t'($urandom_range(0, 2));
			end
			// The receiver holds off while the sender keeps offering items, so the
			// block fills up and has to stall its input.
			if (requests_sent == 10) begin
				tx_bursty = 1'b0;
				hold_requests++;
			end
			// The sender goes quiet until every expected result has come back.
			if (requests_sent == 20) begin
				req_valid <= 1'b0;
				do
					@(posedge clk);
				while (pending_results.size() != 0);
			end
			if ($urandom_range(0, 7) == 0)
				send_noise();
			else
				send_request();
			requests_sent++;
		end

		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d items in %0d random requests: %0d ended cleanly, %0d failed",
			items_sent, requests_sent, clean_requests, failed_requests);
		$display("%0d results checked, %0d RawQuery and %0d StoredProcedure commands seen",
			results_seen, raw_commands, stored_commands);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
